[rtl/core/range_add_range_min_tree_macros.svh]
// Assertion helpers for the checker of the range-minimum tree.
`ifndef RANGE_ADD_RANGE_MIN_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_MIN_TREE_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define RARM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A signal that must not move in the cycle after a condition.
`define RARM_HOLD(lbl, clk, rstn, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

[rtl/core/rarm_pkg.sv]
`timescale 1ns / 1ps
package rarm_pkg;

    localparam int DW = 32;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [DW-1:0] sum;
        logic          ovf;
        logic          le;
    } alu_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

[rtl/core/rarm_ram.sv]
`timescale 1ns / 1ps
module rarm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/rarm_alu.sv]
`timescale 1ns / 1ps
module rarm_alu
    import rarm_pkg::*;
(
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    output alu_res_t      res
);

    logic [DW-1:0] sum;

    assign sum     = op_a + op_b;
    assign res.sum = sum;
    // Signed wrap: both operands disagree in sign with the sum.
    assign res.ovf = ((op_a[DW-1] ^ sum[DW-1]) & (op_b[DW-1] ^ sum[DW-1]));
    assign res.le  = ($signed(op_a) <= $signed(op_b));

endmodule

[rtl/core/rarm_seq.sv]
`timescale 1ns / 1ps
module rarm_seq
    import rarm_pkg::*;
#(
    parameter int POSITIONS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             req_kind,
    input  logic [$clog2(POSITIONS+1)-1:0]   req_lo,
    input  logic [$clog2(POSITIONS+1)-1:0]   req_hi,
    input  logic [DW-1:0]                    req_delta,
    input  logic                             take,
    output seq_stat_t                        stat,
    output logic [DW-1:0]                    res_value,
    output logic [$clog2(POSITIONS)-1:0]     res_index,
    output logic                             res_empty,
    output logic                             res_ovf
);

    localparam int IW     = $clog2(POSITIONS);
    localparam int PW     = $clog2(POSITIONS + 1);
    localparam int LVLS   = IW;
    localparam int NAW    = IW + 1;
    localparam int NDEPTH = 2 ** NAW;
    localparam int LW     = $clog2(LVLS + 1);
    localparam int SIW    = (LVLS > 1) ? $clog2(LVLS) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_VISIT = 4'd3;
    localparam logic [3:0] S_RD_N  = 4'd4;
    localparam logic [3:0] S_HD_L  = 4'd5;
    localparam logic [3:0] S_HD_R  = 4'd6;
    localparam logic [3:0] S_DESC  = 4'd7;
    localparam logic [3:0] S_RET   = 4'd8;
    localparam logic [3:0] S_PU_L  = 4'd9;
    localparam logic [3:0] S_PU_R  = 4'd10;
    localparam logic [3:0] S_PU_W  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    typedef struct packed {
        logic          touched;
        logic [DW-1:0] value;
        logic [DW-1:0] pending;
        logic [IW-1:0] pos;
    } node_word_t;

    localparam int NWW = $bits(node_word_t);

    logic [3:0]     state_reg, state_next;
    logic [NAW-1:0] clr_reg, clr_next;
    logic [NAW-1:0] node_reg, node_next;
    logic [PW-1:0]  lo_reg, lo_next;
    logic [PW-1:0]  hi_reg, hi_next;
    logic [LW-1:0]  lvl_reg, lvl_next;
    logic           kind_reg, kind_next;
    logic [PW-1:0]  a_reg, a_next;
    logic [PW-1:0]  b_reg, b_next;
    logic [DW-1:0]  delta_reg, delta_next;
    logic [DW-1:0]  pend_reg, pend_next;
    logic [DW-1:0]  lw_val_reg, lw_val_next;
    logic [IW-1:0]  lw_pos_reg, lw_pos_next;
    logic           acc_valid_reg, acc_valid_next;
    logic [DW-1:0]  acc_val_reg, acc_val_next;
    logic [IW-1:0]  acc_pos_reg, acc_pos_next;
    logic           ovf_reg, ovf_next;

    logic [PW-1:0]  lo_stk [LVLS];
    logic [PW-1:0]  hi_stk [LVLS];
    logic           push;
    logic [SIW-1:0] push_idx;
    logic [SIW-1:0] pop_idx;
    logic [LW-1:0]  lvl_m1;

    logic           ram_we;
    logic [NAW-1:0] ram_waddr;
    logic [NAW-1:0] ram_raddr;
    node_word_t     wword;
    logic [NWW-1:0] ram_rdata;
    node_word_t     rword;

    logic [DW-1:0]  alu_a, alu_b;
    alu_res_t       alu;
    logic [DW-1:0]  pend_sum;

    logic [PW-1:0]  mid;
    logic [NAW-1:0] lft, rgt;
    logic           no_overlap, covered;
    logic [IW-1:0]  pos_base, pos_r;
    logic [PW-1:0]  hi_clamped;

    rarm_ram #(
        .WIDTH (NWW),
        .DEPTH (NDEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wword),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rword = node_word_t'(ram_rdata);

    rarm_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu)
    );

    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lft        = {node_reg[NAW-2:0], 1'b0};
    assign rgt        = {node_reg[NAW-2:0], 1'b1};
    assign no_overlap = (b_reg <= lo_reg) || (hi_reg <= a_reg);
    assign covered    = (a_reg <= lo_reg) && (hi_reg <= b_reg);
    assign lvl_m1     = lvl_reg - LW'(1);
    assign push_idx   = lvl_reg[SIW-1:0];
    assign pop_idx    = lvl_m1[SIW-1:0];
    assign hi_clamped = (req_hi > PW'(POSITIONS)) ? PW'(POSITIONS) : req_hi;

    // A node never written since the clearing pass holds its lowest position.
    assign pos_base = ((state_reg == S_HD_R) || (state_reg == S_PU_W)) ? mid[IW-1:0]
                                                                       : lo_reg[IW-1:0];
    assign pos_r    = rword.touched ? rword.pos : pos_base;
    assign pend_sum = rword.pending + ((state_reg == S_RD_N) ? delta_reg : pend_reg);

    always_comb
    begin
        unique case (state_reg)
            S_RD_N:
            begin
                if (kind_reg == REQ_ADD)
                begin
                    alu_a = rword.value;
                    alu_b = delta_reg;
                end
                else
                begin
                    alu_a = acc_val_reg;
                    alu_b = rword.value;
                end
            end
            S_PU_W:
            begin
                alu_a = lw_val_reg;
                alu_b = rword.value;
            end
            default:
            begin
                alu_a = rword.value;
                alu_b = pend_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        lvl_next       = lvl_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        delta_next     = delta_reg;
        pend_next      = pend_reg;
        lw_val_next    = lw_val_reg;
        lw_pos_next    = lw_pos_reg;
        acc_valid_next = acc_valid_reg;
        acc_val_next   = acc_val_reg;
        acc_pos_next   = acc_pos_reg;
        ovf_next       = ovf_reg;
        push           = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = node_reg;
        ram_raddr      = node_reg;
        wword          = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + NAW'(1);
                if (clr_reg == NAW'(NDEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next      = req_kind;
                    a_next         = req_lo;
                    b_next         = hi_clamped;
                    delta_next     = req_delta;
                    acc_valid_next = 1'b0;
                    state_next     = S_START;
                end
            end
            S_START:
            begin
                if (a_reg < b_reg)
                begin
                    node_next  = NAW'(1);
                    lo_next    = '0;
                    hi_next    = PW'(POSITIONS);
                    lvl_next   = '0;
                    state_next = S_VISIT;
                end
                else if (kind_reg == REQ_QUERY)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_VISIT:
            begin
                state_next = no_overlap ? S_RET : S_RD_N;
            end
            S_RD_N:
            begin
                if (covered)
                begin
                    if (kind_reg == REQ_ADD)
                    begin
                        ram_we        = 1'b1;
                        wword.touched = 1'b1;
                        wword.value   = alu.sum;
                        wword.pending = pend_sum;
                        wword.pos     = pos_r;
                        if (alu.ovf)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (!acc_valid_reg || !alu.le)
                    begin
                        acc_valid_next = 1'b1;
                        acc_val_next   = rword.value;
                        acc_pos_next   = pos_r;
                    end
                    state_next = S_RET;
                end
                else
                begin
                    // Partly covered: clear the pending add and hand it down.
                    ram_we        = 1'b1;
                    wword.touched = 1'b1;
                    wword.value   = rword.value;
                    wword.pending = '0;
                    wword.pos     = pos_r;
                    pend_next     = rword.pending;
                    ram_raddr     = lft;
                    state_next    = (rword.pending != '0) ? S_HD_L : S_DESC;
                end
            end
            S_HD_L, S_HD_R:
            begin
                ram_we        = 1'b1;
                ram_waddr     = (state_reg == S_HD_L) ? lft : rgt;
                wword.touched = 1'b1;
                wword.value   = alu.sum;
                wword.pending = pend_sum;
                wword.pos     = pos_r;
                ram_raddr     = rgt;
                if (alu.ovf)
                begin
                    ovf_next = 1'b1;
                end
                state_next = (state_reg == S_HD_L) ? S_HD_R : S_DESC;
            end
            S_DESC:
            begin
                push       = 1'b1;
                lvl_next   = lvl_reg + LW'(1);
                node_next  = lft;
                hi_next    = mid;
                state_next = S_VISIT;
            end
            S_RET:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = (kind_reg == REQ_QUERY) ? S_DONE : S_IDLE;
                end
                else if (!node_reg[0])
                begin
                    node_next  = node_reg + NAW'(1);
                    lo_next    = hi_reg;
                    hi_next    = hi_stk[pop_idx];
                    state_next = S_VISIT;
                end
                else
                begin
                    node_next  = node_reg >> 1;
                    lvl_next   = lvl_m1;
                    lo_next    = lo_stk[pop_idx];
                    hi_next    = hi_stk[pop_idx];
                    state_next = (kind_reg == REQ_ADD) ? S_PU_L : S_RET;
                end
            end
            S_PU_L:
            begin
                ram_raddr  = lft;
                state_next = S_PU_R;
            end
            S_PU_R:
            begin
                lw_val_next = rword.value;
                lw_pos_next = pos_r;
                ram_raddr   = rgt;
                state_next  = S_PU_W;
            end
            S_PU_W:
            begin
                ram_we        = 1'b1;
                wword.touched = 1'b1;
                wword.pending = '0;
                // Ties go to the left child, which holds the lower positions.
                wword.value   = alu.le ? lw_val_reg : rword.value;
                wword.pos     = alu.le ? lw_pos_reg : pos_r;
                state_next    = S_RET;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            lvl_reg       <= '0;
            acc_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lvl_reg       <= lvl_next;
            acc_valid_reg <= acc_valid_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        kind_reg    <= kind_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        delta_reg   <= delta_next;
        pend_reg    <= pend_next;
        lw_val_reg  <= lw_val_next;
        lw_pos_reg  <= lw_pos_next;
        acc_val_reg <= acc_val_next;
        acc_pos_reg <= acc_pos_next;
        if (push)
        begin
            lo_stk[push_idx] <= lo_reg;
            hi_stk[push_idx] <= hi_reg;
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign res_value = acc_valid_reg ? acc_val_reg : '0;
    assign res_index = acc_valid_reg ? acc_pos_reg : '0;
    assign res_empty = !acc_valid_reg;
    assign res_ovf   = ovf_reg;

endmodule

[rtl/core/range_add_range_min_tree.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Fields
// in       input      in_valid/in_stall  req_type, range_lo, range_hi, delta
// out      output     out_valid/out_stall min_value, min_index, empty_range, overflow_seen
//
// One word at a time. A request walks the tree node by node (about two partly covered nodes
// per level); the single read and write port of the node store sets its pace.
// After reset a clearing pass writes all 2**(clog2(POSITIONS)+1) node words with in_stall high.
// A query result waits in the output register while the next word is already taken.
module range_add_range_min_tree
    import rarm_pkg::*;
#(
    parameter int POSITIONS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic [$clog2(POSITIONS+1)-1:0] range_lo,
    input  logic [$clog2(POSITIONS+1)-1:0] range_hi,
    input  logic signed [DW-1:0]           delta,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [DW-1:0]           min_value,
    output logic [$clog2(POSITIONS)-1:0]   min_index,
    output logic                           empty_range,
    output logic                           overflow_seen
);

    localparam int IW = $clog2(POSITIONS);

    seq_stat_t      stat;
    logic           start;
    logic           take;
    logic [DW-1:0]  res_value;
    logic [IW-1:0]  res_index;
    logic           res_empty;
    logic           res_ovf;

    logic           out_valid_reg, out_valid_next;
    logic [DW-1:0]  value_reg;
    logic [IW-1:0]  index_reg;
    logic           empty_reg;
    logic           ovf_reg;

    assign in_stall = !stat.idle;
    assign start    = in_valid && stat.idle;
    assign take     = stat.done && (!out_valid_reg || !out_stall);

    rarm_seq #(
        .POSITIONS (POSITIONS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_kind  (req_type),
        .req_lo    (range_lo),
        .req_hi    (range_hi),
        .req_delta (delta),
        .take      (take),
        .stat      (stat),
        .res_value (res_value),
        .res_index (res_index),
        .res_empty (res_empty),
        .res_ovf   (res_ovf)
    );

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= res_value;
            index_reg <= res_index;
            empty_reg <= res_empty;
            ovf_reg   <= res_ovf;
        end
    end

    assign out_valid     = out_valid_reg;
    assign min_value     = value_reg;
    assign min_index     = index_reg;
    assign empty_range   = empty_reg;
    assign overflow_seen = ovf_reg;

endmodule

[rtl/core/rarm_chk.sv]
`timescale 1ns / 1ps
`include "range_add_range_min_tree_macros.svh"
module rarm_chk
    import rarm_pkg::*;
#(
    parameter int POSITIONS = 1024
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           req_type,
    input logic [$clog2(POSITIONS+1)-1:0] range_lo,
    input logic [$clog2(POSITIONS+1)-1:0] range_hi,
    input logic signed [DW-1:0]           delta,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [DW-1:0]           min_value,
    input logic [$clog2(POSITIONS)-1:0]   min_index,
    input logic                           empty_range,
    input logic                           overflow_seen
);

    `RARM_ASSERT(a_out_held, clk, rst_n, out_valid && out_stall |=> out_valid, "result word dropped while stalled")
    `RARM_HOLD(a_out_stable, clk, rst_n, out_valid && out_stall, min_value, "stalled result changed")
    `RARM_ASSERT(a_empty_zero, clk, rst_n, out_valid && empty_range |-> (min_value == '0) && (min_index == '0), "empty range with non-zero result")
    `RARM_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "second word taken before the first was worked")
    `RARM_ASSERT(a_ovf_sticky, clk, rst_n, out_valid && !out_stall && overflow_seen ##1 out_valid |-> overflow_seen, "overflow flag cleared")

endmodule

bind range_add_range_min_tree rarm_chk #(.POSITIONS(POSITIONS)) u_rarm_chk (.*);
